>>> hdl/assert_macros.svh
// assertion helpers included by the flow table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// implication checked on every clock edge out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/hhft_pkg.sv
// ----------------------------------------------------------------------------
// hhft_pkg
// Types and codes shared by the flow table and its divider.
// ----------------------------------------------------------------------------
package hhft_pkg;

    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int PORT_W  = 16;
    localparam int CNT_W   = 32;
    localparam int TIME_W  = 48;
    localparam int RATE_W  = 40;
    localparam int TPS_W   = 32;
    localparam int PROD_W  = 64;
    localparam int CFG_W   = 48;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    // input op codes
    localparam logic [1:0] OP_PACKET  = 2'd0;
    localparam logic [1:0] OP_SWEEP   = 2'd1;
    localparam logic [1:0] OP_SUMMARY = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PACKET  = 2'd0;
    localparam logic [1:0] KIND_SWEEP   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // result status
    localparam logic [1:0] ST_EXISTING = 2'd0;
    localparam logic [1:0] ST_NEW      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_MIN_SPAN = 2'd1;
    localparam logic [1:0] CFG_TPS      = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PROTO_W-1:0] protocol;
        logic [PORT_W-1:0]  src_port;
        logic [PORT_W-1:0]  dst_port;
    } t_flow_key;

    typedef struct packed {
        logic              valid;
        t_flow_key         key;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] first_seen;
        logic [TIME_W-1:0] last_seen;
    } t_flow_rec;

endpackage

>>> hdl/hhft_ram.sv
// ----------------------------------------------------------------------------
// hhft_ram
// Simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hhft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/hhft_div.sv
// ----------------------------------------------------------------------------
// hhft_div
// Restoring divider, one quotient bit per cycle, 64 by 48 bits.
// ----------------------------------------------------------------------------
module hhft_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hhft_pkg::PROD_W-1:0] i_dividend,
    input  logic [hhft_pkg::TIME_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [hhft_pkg::PROD_W-1:0] o_quot
);
    import hhft_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [TIME_W:0]   r_rem;
    logic [PROD_W-1:0] r_quot;
    logic [TIME_W-1:0] r_div;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W+1:0] trial;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem[TIME_W-1:0], r_quot[PROD_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!trial[TIME_W+1]) begin
                    r_rem  <= trial[TIME_W:0];
                    r_quot <= {r_quot[PROD_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_quot <= {r_quot[PROD_W-2:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hdl/heavy_hitter_flow_table.sv
// ----------------------------------------------------------------------------
// heavy_hitter_flow_table
// Per-flow packet counter keyed by the IPv4 five-tuple with idle expiry and
// a top-rate summary.
// ----------------------------------------------------------------------------
// All flow records sit in one ram of TABLE_ENTRIES words; packet and sweep
// walks read one entry per cycle. After reset a clearing pass over every
// entry runs before the first input word is taken (configuration writes are
// taken throughout). One input word is worked on at a time. A packet walks
// the table until its flow matches; a sweep always walks the whole table. A
// summary visits every entry: an empty slot is read and checked; a valid
// flow also passes the bit-serial 64 bit divider when its span is long enough
// and the serial search for the list minimum once the list is full; then
// TOP_COUNT sort passes and a read and an emit step for each reported flow. A
// finished result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module heavy_hitter_flow_table #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int TOP_COUNT     = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [1:0]                             i_cfg_index,
    input  logic [hhft_pkg::CFG_W-1:0]             i_cfg_data,
    // input words
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_op,
    input  logic [hhft_pkg::ADDR_W-1:0]            i_src_addr,
    input  logic [hhft_pkg::ADDR_W-1:0]            i_dst_addr,
    input  logic [hhft_pkg::PROTO_W-1:0]           i_protocol,
    input  logic [hhft_pkg::PORT_W-1:0]            i_src_port,
    input  logic [hhft_pkg::PORT_W-1:0]            i_dst_port,
    input  logic [hhft_pkg::TIME_W-1:0]            i_now,
    // result words
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [1:0]                             o_kind,
    output logic [1:0]                             o_status,
    output logic [hhft_pkg::ADDR_W-1:0]            o_flow_src_addr,
    output logic [hhft_pkg::ADDR_W-1:0]            o_flow_dst_addr,
    output logic [hhft_pkg::PROTO_W-1:0]           o_flow_protocol,
    output logic [hhft_pkg::PORT_W-1:0]            o_flow_src_port,
    output logic [hhft_pkg::PORT_W-1:0]            o_flow_dst_port,
    output logic [hhft_pkg::RATE_W-1:0]            o_packet_rate,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]     o_flows_in_table,
    output logic [hhft_pkg::RATE_W-1:0]            o_top_rate,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]     o_removed_count,
    output logic                                   o_last
);
    import hhft_pkg::*;

    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int NW = $clog2(TOP_COUNT + 1);
    localparam int TW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam logic [SW:0] SCAN_END  = (SW + 1)'(TABLE_ENTRIES);
    localparam logic [SW:0] SCAN_LAST = (SW + 1)'(TABLE_ENTRIES - 1);

    // state codes
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_PK_SCAN = 4'd2;
    localparam logic [3:0] S_PK_UPD  = 4'd3;
    localparam logic [3:0] S_SW_SCAN = 4'd4;
    localparam logic [3:0] S_SW_DONE = 4'd5;
    localparam logic [3:0] S_SM_RD   = 4'd6;
    localparam logic [3:0] S_SM_CHK  = 4'd7;
    localparam logic [3:0] S_SM_MUL  = 4'd8;
    localparam logic [3:0] S_SM_DIV  = 4'd9;
    localparam logic [3:0] S_SM_SEL  = 4'd10;
    localparam logic [3:0] S_SM_MIN  = 4'd11;
    localparam logic [3:0] S_SM_SORT = 4'd12;
    localparam logic [3:0] S_SM_ORD  = 4'd13;
    localparam logic [3:0] S_SM_EMIT = 4'd14;

    logic [3:0]        r_state;

    // configuration registers
    logic [TIME_W-1:0] r_timeout;
    logic [TIME_W-1:0] r_min_span;
    logic [TPS_W-1:0]  r_tps;

    // latched input word
    t_flow_key         r_key;
    logic [TIME_W-1:0] r_now;

    // table walk
    logic [SW:0]       r_scan;
    logic [SW-1:0]     r_chk;
    logic              r_chk_v;
    logic              r_hit;
    logic [SW-1:0]     r_slot;
    t_flow_rec         r_rec;
    logic              r_free_v;
    logic [SW-1:0]     r_free;
    logic [CW-1:0]     r_flows;
    logic [CW-1:0]     r_removed;

    // rate computation
    logic [CNT_W-1:0]  r_cm1;
    logic [TIME_W-1:0] r_span;
    logic [PROD_W-1:0] r_prod;
    logic              r_div_start;
    logic [RATE_W-1:0] r_rate;

    // top list
    logic [SW-1:0]     r_top_slot [TOP_COUNT];
    logic [RATE_W-1:0] r_top_rate [TOP_COUNT];
    logic [NW-1:0]     r_n;
    logic [NW-1:0]     r_mi_i;
    logic [TW-1:0]     r_mi;
    logic [RATE_W-1:0] r_mr;
    logic [NW-1:0]     r_pass;
    logic [NW-1:0]     r_oi;

    // output register
    logic              r_out_valid;
    logic [1:0]        r_o_kind;
    logic [1:0]        r_o_status;
    t_flow_key         r_o_key;
    logic [RATE_W-1:0] r_o_rate;
    logic [CW-1:0]     r_o_flows;
    logic [RATE_W-1:0] r_o_top;
    logic [CW-1:0]     r_o_removed;
    logic              r_o_last;

    // ram port
    logic              ram_we;
    logic [SW-1:0]     ram_waddr;
    t_flow_rec         ram_wdata;
    logic [SW-1:0]     ram_raddr;
    t_flow_rec         ram_rdata;

    logic              div_done;
    logic [PROD_W-1:0] div_quot;

    logic              out_free;
    logic              in_acc;
    logic [TIME_W-1:0] idle_age;
    logic              expired;
    logic              key_hit;
    t_flow_rec         n_rec;
    logic [1:0]        n_status;
    logic [CW-1:0]     n_flows;
    logic [SW-1:0]     n_sort_slot [TOP_COUNT];
    logic [RATE_W-1:0] n_sort_rate [TOP_COUNT];

    hhft_ram #(
        .WIDTH ($bits(t_flow_rec)),
        .DEPTH (TABLE_ENTRIES)
    ) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hhft_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;
    assign idle_age = r_now - ram_rdata.last_seen;
    assign expired  = ram_rdata.valid && (idle_age >= r_timeout);
    assign key_hit  = ram_rdata.valid && (ram_rdata.key == r_key);

    // packet update record and status
    always_comb begin
        n_rec    = r_rec;
        n_status = ST_FULL;
        n_flows  = r_flows;
        if (r_hit) begin
            if (r_rec.count != CNT_MAX) begin
                n_rec.count = r_rec.count + 1'b1;
            end
            n_rec.last_seen = r_now;
            n_status        = ST_EXISTING;
        end else if (r_free_v) begin
            n_rec.valid      = 1'b1;
            n_rec.key        = r_key;
            n_rec.count      = CNT_W'(1);
            n_rec.first_seen = r_now;
            n_rec.last_seen  = r_now;
            n_status         = ST_NEW;
            n_flows          = r_flows + 1'b1;
        end
    end

    // one odd-even transposition pass over the top list
    always_comb begin
        n_sort_slot = r_top_slot;
        n_sort_rate = r_top_rate;
        for (int k = 0; k < TOP_COUNT - 1; k++) begin
            if ((k % 2) == (r_pass[0] ? 1 : 0) && (k + 1) < int'(r_n) &&
                r_top_rate[k+1] > r_top_rate[k]) begin
                n_sort_slot[k]   = r_top_slot[k+1];
                n_sort_slot[k+1] = r_top_slot[k];
                n_sort_rate[k]   = r_top_rate[k+1];
                n_sort_rate[k+1] = r_top_rate[k];
            end
        end
    end

    // ram address and write control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_chk;
        ram_wdata = ram_rdata;
        ram_raddr = r_scan[SW-1:0];
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_scan[SW-1:0];
                ram_wdata = '0;
            end
            S_SW_SCAN: begin
                ram_we          = r_chk_v && expired;
                ram_wdata.valid = 1'b0;
            end
            S_PK_UPD: begin
                ram_we    = out_free && (r_hit || r_free_v);
                ram_waddr = r_hit ? r_slot : r_free;
                ram_wdata = n_rec;
            end
            S_SM_ORD, S_SM_EMIT: begin
                ram_raddr = r_top_slot[r_oi[TW-1:0]];
            end
            default: begin
                ram_raddr = r_scan[SW-1:0];
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIME_W'(1000000000);
            r_min_span <= TIME_W'(20000000);
            r_tps      <= TPS_W'(1000000000);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TIME_W-1:0];
                CFG_MIN_SPAN: r_min_span <= i_cfg_data[TIME_W-1:0];
                CFG_TPS:      r_tps      <= i_cfg_data[TPS_W-1:0];
                default:      ;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_chk_v     <= 1'b0;
            r_flows     <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_n         <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // clear every valid bit after reset
                S_CLEAR: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == SCAN_LAST) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_acc) begin
                        r_key     <= '{i_src_addr, i_dst_addr, i_protocol,
                                       i_src_port, i_dst_port};
                        r_now     <= i_now;
                        r_scan    <= '0;
                        r_chk_v   <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_v  <= 1'b0;
                        r_removed <= '0;
                        r_n       <= '0;
                        case (i_op)
                            OP_PACKET:  r_state <= S_PK_SCAN;
                            OP_SWEEP:   r_state <= S_SW_SCAN;
                            OP_SUMMARY: r_state <= S_SM_RD;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end

                // look for the flow, note the lowest free slot
                S_PK_SCAN: begin
                    if (r_chk_v && key_hit) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_chk;
                        r_rec   <= ram_rdata;
                        r_chk_v <= 1'b0;
                        r_state <= S_PK_UPD;
                    end else begin
                        if (r_chk_v && !ram_rdata.valid && !r_free_v) begin
                            r_free_v <= 1'b1;
                            r_free   <= r_chk;
                        end
                        if (r_scan != SCAN_END) begin
                            r_scan  <= r_scan + 1'b1;
                            r_chk   <= r_scan[SW-1:0];
                            r_chk_v <= 1'b1;
                        end else begin
                            r_chk_v <= 1'b0;
                            if (!r_chk_v) begin
                                r_state <= S_PK_UPD;
                            end
                        end
                    end
                end

                S_PK_UPD: begin
                    if (out_free) begin
                        r_flows     <= n_flows;
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_PACKET;
                        r_o_status  <= n_status;
                        r_o_key     <= r_key;
                        r_o_rate    <= '0;
                        r_o_flows   <= n_flows;
                        r_o_top     <= '0;
                        r_o_removed <= '0;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                // expire idle flows, write back cleared valid bit
                S_SW_SCAN: begin
                    if (r_chk_v && expired) begin
                        r_flows   <= r_flows - 1'b1;
                        r_removed <= r_removed + 1'b1;
                    end
                    if (r_scan != SCAN_END) begin
                        r_scan  <= r_scan + 1'b1;
                        r_chk   <= r_scan[SW-1:0];
                        r_chk_v <= 1'b1;
                    end else begin
                        r_chk_v <= 1'b0;
                        if (!r_chk_v) begin
                            r_state <= S_SW_DONE;
                        end
                    end
                end

                S_SW_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_SWEEP;
                        r_o_status  <= ST_EXISTING;
                        r_o_key     <= '0;
                        r_o_rate    <= '0;
                        r_o_flows   <= r_flows;
                        r_o_top     <= '0;
                        r_o_removed <= r_removed;
                        r_o_last    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                // summary: read one entry
                S_SM_RD: begin
                    r_state <= S_SM_CHK;
                end

                S_SM_CHK: begin
                    if (ram_rdata.valid) begin
                        r_slot  <= r_scan[SW-1:0];
                        r_cm1   <= (ram_rdata.count == '0) ? '0 : ram_rdata.count - 1'b1;
                        r_span  <= ram_rdata.last_seen - ram_rdata.first_seen;
                        r_state <= S_SM_MUL;
                    end else if (r_scan == SCAN_LAST) begin
                        r_pass  <= '0;
                        r_state <= S_SM_SORT;
                    end else begin
                        r_scan  <= r_scan + 1'b1;
                        r_state <= S_SM_RD;
                    end
                end

                // count minus one times ticks per second, then divide by span
                S_SM_MUL: begin
                    r_prod <= {{(PROD_W - CNT_W){1'b0}}, r_cm1} *
                              {{(PROD_W - TPS_W){1'b0}}, r_tps};
                    if (r_span == '0 || r_span < r_min_span) begin
                        r_rate  <= '0;
                        r_state <= S_SM_SEL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_SM_DIV;
                    end
                end

                S_SM_DIV: begin
                    if (div_done) begin
                        r_rate  <= (|div_quot[PROD_W-1:RATE_W]) ? RATE_MAX
                                                                : div_quot[RATE_W-1:0];
                        r_state <= S_SM_SEL;
                    end
                end

                // append while the list has room, else search its minimum
                S_SM_SEL: begin
                    if (r_n < NW'(TOP_COUNT)) begin
                        r_top_slot[r_n[TW-1:0]] <= r_slot;
                        r_top_rate[r_n[TW-1:0]] <= r_rate;
                        r_n <= r_n + 1'b1;
                        if (r_scan == SCAN_LAST) begin
                            r_pass  <= '0;
                            r_state <= S_SM_SORT;
                        end else begin
                            r_scan  <= r_scan + 1'b1;
                            r_state <= S_SM_RD;
                        end
                    end else begin
                        r_mr    <= r_top_rate[0];
                        r_mi    <= '0;
                        r_mi_i  <= NW'(1);
                        r_state <= S_SM_MIN;
                    end
                end

                // first minimum, one list entry per cycle
                S_SM_MIN: begin
                    if (r_mi_i != NW'(TOP_COUNT)) begin
                        if (r_top_rate[r_mi_i[TW-1:0]] < r_mr) begin
                            r_mr <= r_top_rate[r_mi_i[TW-1:0]];
                            r_mi <= r_mi_i[TW-1:0];
                        end
                        r_mi_i <= r_mi_i + 1'b1;
                    end else begin
                        if (r_rate > r_mr) begin
                            r_top_slot[r_mi] <= r_slot;
                            r_top_rate[r_mi] <= r_rate;
                        end
                        if (r_scan == SCAN_LAST) begin
                            r_pass  <= '0;
                            r_state <= S_SM_SORT;
                        end else begin
                            r_scan  <= r_scan + 1'b1;
                            r_state <= S_SM_RD;
                        end
                    end
                end

                // stable descending sort
                S_SM_SORT: begin
                    r_oi <= '0;
                    if (r_n == '0) begin
                        r_state <= S_SM_EMIT;
                    end else if (r_pass == NW'(TOP_COUNT)) begin
                        r_state <= S_SM_ORD;
                    end else begin
                        r_top_slot <= n_sort_slot;
                        r_top_rate <= n_sort_rate;
                        r_pass     <= r_pass + 1'b1;
                    end
                end

                S_SM_ORD: begin
                    r_state <= S_SM_EMIT;
                end

                S_SM_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_SUMMARY;
                        r_o_flows   <= r_flows;
                        r_o_removed <= '0;
                        if (r_n == '0) begin
                            r_o_status <= ST_NONE;
                            r_o_key    <= '0;
                            r_o_rate   <= '0;
                            r_o_top    <= '0;
                            r_o_last   <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_o_status <= ST_EXISTING;
                            r_o_key    <= ram_rdata.key;
                            r_o_rate   <= r_top_rate[r_oi[TW-1:0]];
                            r_o_top    <= r_top_rate[0];
                            r_o_last   <= (r_oi == r_n - 1'b1);
                            if (r_oi == r_n - 1'b1) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_oi    <= r_oi + 1'b1;
                                r_state <= S_SM_ORD;
                            end
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_o_kind;
    assign o_status         = r_o_status;
    assign o_flow_src_addr  = r_o_key.src_addr;
    assign o_flow_dst_addr  = r_o_key.dst_addr;
    assign o_flow_protocol  = r_o_key.protocol;
    assign o_flow_src_port  = r_o_key.src_port;
    assign o_flow_dst_port  = r_o_key.dst_port;
    assign o_packet_rate    = r_o_rate;
    assign o_flows_in_table = r_o_flows;
    assign o_top_rate       = r_o_top;
    assign o_removed_count  = r_o_removed;
    assign o_last           = r_o_last;

    // checks
    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_flows_bound, r_flows <= CW'(TABLE_ENTRIES), "flow count exceeds table")
    `ASSERT_ALWAYS(a_list_bound, r_n <= NW'(TOP_COUNT), "top list overfilled")
    `ASSERT_IMPLY(a_sorted, o_out_valid && o_kind == KIND_SUMMARY, o_packet_rate <= o_top_rate, "summary word above top rate")

endmodule
